/* sv/rnm_pkg.sv */
// Shared types, constants and NFA helper functions for the regex NFA matcher.
package rnm_pkg;

  localparam int unsigned MaxTokens  = 16;
  localparam int unsigned StateW     = MaxTokens + 1;
  localparam int unsigned CountW     = 5;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] WildcardByte = 8'd46;

  localparam logic ModeStart = 1'b0;
  localparam logic ModeByte  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOK_LOW   = 2'd0,
    CFG_TOK_HIGH  = 2'd1,
    CFG_STAR_MASK = 2'd2,
    CFG_TOK_COUNT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2*CfgDataW-1:0] token_bytes;
    logic [MaxTokens-1:0]  star_mask;
    logic [CountW-1:0]     tok_count;  // saturated to MaxTokens
  } rnm_cfg_t;

  typedef struct packed {
    logic                 mode;
    logic [MaxTokens-1:0] hit;
  } rnm_item_t;

  // bits 0..n set
  function automatic logic [StateW-1:0] valid_mask(input logic [CountW-1:0] n);
    logic [StateW-1:0] m;
    for (int k = 0; k < StateW; k++) begin
      m[k] = (CountW'(k) <= n);
    end
    return m;
  endfunction

  // starred active states also enable the next state, rippling upward
  function automatic logic [StateW-1:0] eps_closure(input logic [StateW-1:0] s,
                                                    input logic [MaxTokens-1:0] star,
                                                    input logic [CountW-1:0] n);
    logic [StateW-1:0] r;
    r = s;
    for (int k = 0; k < MaxTokens; k++) begin
      if (r[k] && star[k] && (CountW'(k) < n)) begin
        r[k+1] = 1'b1;
      end
    end
    return r & valid_mask(n);
  endfunction

endpackage

/* sv/rnm_if.sv */
// Valid/ready channel interfaces for input bytes and match results.
interface rnm_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink   (input valid, input mode, input symbol, output ready);
endinterface

interface rnm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic alive;

  modport source (output valid, output matched, output alive, input ready);
  modport sink   (input valid, input matched, input alive, output ready);
endinterface

/* sv/rnm_front.sv */
// Front end: accepts input beats and classifies the symbol against every token.
module rnm_front (
  input  logic [2*rnm_pkg::CfgDataW-1:0] token_bytes_i,
  rnm_in_if.sink                         in_ch,
  output logic                           push_valid_o,
  output rnm_pkg::rnm_item_t             push_item_o,
  input  logic                           push_ready_i
);

  logic [rnm_pkg::MaxTokens-1:0] hit;

  always_comb begin
    for (int k = 0; k < rnm_pkg::MaxTokens; k++) begin
      hit[k] = (token_bytes_i[8*k +: 8] == rnm_pkg::WildcardByte) ||
               (token_bytes_i[8*k +: 8] == in_ch.symbol);
    end
  end

  assign in_ch.ready       = push_ready_i;
  assign push_valid_o      = in_ch.valid;
  assign push_item_o.mode  = in_ch.mode;
  assign push_item_o.hit   = hit;

endmodule

/* sv/rnm_queue.sv */
// Short FIFO between the classifying front end and the NFA back end.
module rnm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rnm_pkg::rnm_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rnm_pkg::rnm_item_t pop_item_o
);

  localparam int unsigned PtrW = (rnm_pkg::QueueDepth > 1) ? $clog2(rnm_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(rnm_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rnm_pkg::QueueDepth - 1);

  rnm_pkg::rnm_item_t mem_q [rnm_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CntW'(rnm_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* sv/rnm_back.sv */
// Back end: NFA active-set update, epsilon closure and the result register.
module rnm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pop_valid_i,
  output logic                            pop_ready_o,
  input  rnm_pkg::rnm_item_t              pop_item_i,
  input  logic [rnm_pkg::MaxTokens-1:0]   star_mask_i,
  input  logic [rnm_pkg::CountW-1:0]      tok_count_i,
  rnm_out_if.source                       out_ch
);

  logic [rnm_pkg::StateW-1:0] state_q;
  logic [rnm_pkg::StateW-1:0] cur, step, seed, state_d;
  logic out_valid_q, matched_q, alive_q;
  logic pop;

  assign pop_ready_o = !out_valid_q || out_ch.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    cur  = state_q & rnm_pkg::valid_mask(tok_count_i);
    step = '0;
    for (int k = 0; k < rnm_pkg::MaxTokens; k++) begin
      if (cur[k] && pop_item_i.hit[k] && (rnm_pkg::CountW'(k) < tok_count_i)) begin
        step[k+1] = 1'b1;
        if (star_mask_i[k]) begin
          step[k] = 1'b1;
        end
      end
    end
    seed    = (pop_item_i.mode == rnm_pkg::ModeStart) ? rnm_pkg::StateW'(1) : step;
    state_d = rnm_pkg::eps_closure(seed, star_mask_i, tok_count_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        state_q <= state_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      matched_q <= state_d[tok_count_i];
      alive_q   <= |state_d;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.matched = matched_q;
  assign out_ch.alive   = alive_q;

`ifndef SYNTHESIS
  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_q) else $error("popped beat produced no result");

  a_start_sets_state0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && pop_item_i.mode == rnm_pkg::ModeStart) |=> state_q[0])
    else $error("start beat did not activate state 0");

  a_alive_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (alive_q == (|state_q))) else $error("alive disagrees with active set");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop |=> $stable(state_q)) else $error("active set changed without a beat");
`endif

endmodule

/* sv/regex_nfa_matcher_unit.sv */
// Top level of the regex NFA matcher: config registers, front end, queue, back end.
// Path: an accepted beat is registered in the queue, then its result in the back-end result register.
// Throughput: one beat per cycle while the receiver is ready; the NFA state update and closure ripple over 16 bits.
// The two-entry queue and the result register let either side stall on its own.
// Reset clears the active state set, the queue and all configuration registers.
module regex_nfa_matcher_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rnm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rnm_pkg::CfgDataW-1:0]  cfg_wdata_i,
  rnm_in_if.sink                        in_ch,
  rnm_out_if.source                     out_ch
);

  logic [rnm_pkg::CfgDataW-1:0]  tok_low_q;
  logic [rnm_pkg::CfgDataW-1:0]  tok_high_q;
  logic [rnm_pkg::MaxTokens-1:0] star_mask_q;
  logic [rnm_pkg::CountW-1:0]    tok_count_q;
  rnm_pkg::rnm_cfg_t             cfg;

  logic               push_valid, push_ready, pop_valid, pop_ready;
  rnm_pkg::rnm_item_t push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_low_q   <= '0;
      tok_high_q  <= '0;
      star_mask_q <= '0;
      tok_count_q <= '0;
    end else if (cfg_we_i) begin
      case (rnm_pkg::cfg_idx_e'(cfg_idx_i))
        rnm_pkg::CFG_TOK_LOW:   tok_low_q   <= cfg_wdata_i;
        rnm_pkg::CFG_TOK_HIGH:  tok_high_q  <= cfg_wdata_i;
        rnm_pkg::CFG_STAR_MASK: star_mask_q <= cfg_wdata_i[rnm_pkg::MaxTokens-1:0];
        rnm_pkg::CFG_TOK_COUNT: tok_count_q <= cfg_wdata_i[rnm_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.token_bytes = {tok_high_q, tok_low_q};
  assign cfg.star_mask   = star_mask_q;
  assign cfg.tok_count   = (tok_count_q > rnm_pkg::CountW'(rnm_pkg::MaxTokens)) ?
                           rnm_pkg::CountW'(rnm_pkg::MaxTokens) : tok_count_q;

  rnm_front u_front (
    .token_bytes_i (cfg.token_bytes),
    .in_ch         (in_ch),
    .push_valid_o  (push_valid),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  rnm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  rnm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .star_mask_i (cfg.star_mask),
    .tok_count_i (cfg.tok_count),
    .out_ch      (out_ch)
  );

endmodule

/* test/tb_regex_nfa_matcher_unit.sv */
// Self-checking testbench for the regex NFA matcher: directed and random strings vs a predictor.
module tb_regex_nfa_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic matched;
    logic alive;
  } verdict_t;

  class match_scoreboard;
    logic [63:0] tok_lo;
    logic [63:0] tok_hi;
    logic [15:0] stars;
    logic [4:0]  count_reg;
    logic [16:0] live_set;
    verdict_t    verdict_q[$];
    int          errors;

    function new();
      tok_lo    = '0;
      tok_hi    = '0;
      stars     = '0;
      count_reg = '0;
      live_set  = '0;
      errors    = 0;
    endfunction

    function void write_reg(rnm_pkg::cfg_idx_e idx, logic [63:0] val);
      case (idx)
        rnm_pkg::CFG_TOK_LOW:   tok_lo    = val;
        rnm_pkg::CFG_TOK_HIGH:  tok_hi    = val;
        rnm_pkg::CFG_STAR_MASK: stars     = val[15:0];
        rnm_pkg::CFG_TOK_COUNT: count_reg = val[4:0];
        default: ;
      endcase
    endfunction

    function int n_tokens();
      return (count_reg > 5'd16) ? 16 : int'(count_reg);
    endfunction

    function logic [7:0] tok_byte(int k);
      return (k < 8) ? tok_lo[8*k +: 8] : tok_hi[8*(k-8) +: 8];
    endfunction

    function logic [16:0] span(int n);
      return 17'((33'd2 << n) - 33'd1);
    endfunction

    function logic [16:0] close_up(logic [16:0] s, int n);
      for (int k = 0; k < n; k++) begin
        if (s[k] && stars[k]) s[k+1] = 1'b1;
      end
      return s & span(n);
    endfunction

    function void note_beat(logic mode, logic [7:0] sym);
      int          n;
      logic [16:0] cur;
      logic [16:0] nxt;
      logic [7:0]  b;
      verdict_t    v;
      n   = n_tokens();
      cur = live_set & span(n);
      nxt = '0;
      if (mode == rnm_pkg::ModeStart) begin
        nxt = close_up(17'd1, n);
      end else begin
        for (int k = 0; k < n; k++) begin
          if (cur[k]) begin
            b = tok_byte(k);
            if (b == rnm_pkg::WildcardByte || b == sym) begin
              nxt[k+1] = 1'b1;
              if (stars[k]) nxt[k] = 1'b1;
            end
          end
        end
        nxt = close_up(nxt, n);
      end
      live_set  = nxt;
      v.matched = live_set[n];
      v.alive   = |live_set;
      verdict_q.insert(verdict_q.size(), v);
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(logic matched, logic alive);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        report("result beat with no expectation");
        return;
      end
      want = verdict_q.pop_front();
      if (matched !== want.matched)
        report($sformatf("matched got %b want %b", matched, want.matched));
      if (alive !== want.alive)
        report($sformatf("alive got %b want %b", alive, want.alive));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [rnm_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rnm_pkg::CfgDataW-1:0] cfg_wdata_i;

  rnm_in_if  in_ch ();
  rnm_out_if out_ch ();

  regex_nfa_matcher_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  match_scoreboard verdicts = new();

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int burst_req      = 0;
  int burst_seen     = 0;
  int burst_left     = 0;
  int sent_beats     = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // receiver: random stalls plus long hold-off bursts on request
  always @(posedge clk_i) begin
    if (burst_req != burst_seen) begin
      burst_seen = burst_req;
      burst_left = 80;
    end
    if (burst_left > 0) begin
      burst_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // outputs are stable at the falling edge; the beat completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      verdicts.check_verdict(out_ch.matched, out_ch.alive);
  end

  task automatic send_item(logic mode, logic [7:0] sym);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.symbol <= sym;
    do @(negedge clk_i); while (!in_ch.ready);
    verdicts.note_beat(mode, sym);
    sent_beats++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdicts.pending() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(rnm_pkg::cfg_idx_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    verdicts.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_pattern(logic [63:0] lo, logic [63:0] hi, logic [15:0] st,
                             logic [4:0] cnt);
    write_reg(rnm_pkg::CFG_TOK_LOW, lo);
    write_reg(rnm_pkg::CFG_TOK_HIGH, hi);
    write_reg(rnm_pkg::CFG_STAR_MASK, {48'd0, st});
    write_reg(rnm_pkg::CFG_TOK_COUNT, {59'd0, cnt});
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_token();
    int r;
    r = $urandom_range(9);
    if (r < 2) return rnm_pkg::WildcardByte;
    if (r == 2) return 8'($urandom);
    return 8'h61 + 8'($urandom_range(2));
  endfunction

  function automatic logic [63:0] rand_token_word();
    logic [63:0] w;
    case ($urandom_range(7))
      0: w = {$urandom, $urandom};
      1: w = '1;
      2: w = '0;
      default: begin
        for (int i = 0; i < 8; i++) w[8*i +: 8] = rand_token();
      end
    endcase
    return w;
  endfunction

  function automatic logic [15:0] rand_stars();
    case ($urandom_range(7))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom & $urandom);
    endcase
  endfunction

  function automatic logic [4:0] rand_count();
    case ($urandom_range(15))
      0: return 5'd0;
      1: return 5'($urandom_range(31, 17));
      2: return 5'd16;
      3: return 5'($urandom_range(15, 7));
      default: return 5'($urandom_range(6, 1));
    endcase
  endfunction

  // walks the pattern: starred tokens repeat, wildcards take any byte, rare corruption
  task automatic send_string(bit with_start);
    int         n;
    int         reps;
    logic [7:0] b;
    n = verdicts.n_tokens();
    if (with_start) send_item(rnm_pkg::ModeStart, 8'($urandom));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(24) == 0) break;
      reps = verdicts.stars[k] ? $urandom_range(3) : 1;
      repeat (reps) begin
        b = verdicts.tok_byte(k);
        if (b == rnm_pkg::WildcardByte || $urandom_range(15) == 0) b = 8'($urandom);
        send_item(rnm_pkg::ModeByte, b);
      end
    end
    repeat ($urandom_range(2)) send_item(rnm_pkg::ModeByte, 8'($urandom));
  endtask

  task automatic run_phase(int src_pct, int sink_pct, int beats);
    int base;
    int r;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    base           = sent_beats;
    drain();
    set_pattern(rand_token_word(), rand_token_word(), rand_stars(), rand_count());
    burst_req <= burst_req + 1;
    repeat (30) send_item(rnm_pkg::ModeByte, 8'($urandom));
    while (sent_beats - base < beats) begin
      drain();
      r = $urandom_range(4);
      if (r == 0) begin
        // swap part of the pattern under a live string
        if ($urandom_range(1)) write_reg(rnm_pkg::CFG_TOK_COUNT, {59'd0, rand_count()});
        else write_reg(rnm_pkg::CFG_STAR_MASK, {48'd0, rand_stars()});
        cfg_we_i <= 1'b0;
        send_string(1'b0);
      end else begin
        set_pattern(rand_token_word(), rand_token_word(), rand_stars(), rand_count());
      end
      repeat ($urandom_range(8, 3)) begin
        r = $urandom_range(9);
        if (r < 8) send_string(1'b1);
        else if (r == 8) send_string(1'b0);
        else repeat ($urandom_range(6, 1)) send_item(1'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = rnm_pkg::CFG_TOK_LOW;
    cfg_wdata_i  = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = rnm_pkg::ModeStart;
    in_ch.symbol = 8'd0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte before any start, then the empty pattern
    send_item(rnm_pkg::ModeByte, 8'hFF);
    send_item(rnm_pkg::ModeStart, 8'hA5);
    send_item(rnm_pkg::ModeByte, 8'h00);
    drain();

    // a . b* c
    set_pattern(64'h0000_0000_6362_2E61, '1, 16'h0004, 5'd4);
    send_item(rnm_pkg::ModeStart, 8'h00);
    send_item(rnm_pkg::ModeByte, 8'h61);
    send_item(rnm_pkg::ModeByte, 8'h80);
    send_item(rnm_pkg::ModeByte, 8'h62);
    send_item(rnm_pkg::ModeByte, 8'h62);
    send_item(rnm_pkg::ModeByte, 8'h63);
    send_item(rnm_pkg::ModeByte, 8'h63);
    send_item(rnm_pkg::ModeStart, 8'hFF);
    send_item(rnm_pkg::ModeByte, 8'h61);
    drain();

    // oversized count and all stars under the live string
    set_pattern({8{8'h2E}}, {8{8'h2E}}, 16'hFFFF, 5'd31);
    send_item(rnm_pkg::ModeByte, 8'h7F);
    send_item(rnm_pkg::ModeStart, 8'h5A);
    drain();

    set_pattern({8{8'h2E}}, 64'hFF2E_2E2E_2E2E_2E2E, 16'h7FFF, 5'd16);
    send_item(rnm_pkg::ModeStart, 8'h00);
    send_item(rnm_pkg::ModeByte, 8'hFF);
    send_item(rnm_pkg::ModeByte, 8'h00);

    run_phase(0, 0, 350);
    run_phase(63, 0, 350);
    run_phase(0, 63, 350);
    run_phase(32, 32, 350);

    in_ch.valid <= 1'b0;
    for (int i = 0; i < 20000 && verdicts.pending() != 0; i++) @(negedge clk_i);
    if (verdicts.pending() != 0)
      verdicts.report($sformatf("%0d results never arrived", verdicts.pending()));
    repeat (5) @(posedge clk_i);
    if (verdicts.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
